[hdl/rld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run list decoder package
// Shared types, codes and constants of the run list decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam int          JOB_DEPTH_DEF       = 4;
    localparam int          RES_DEPTH_DEF       = 4;
    localparam logic [4:0]  CLUSTER_SHIFT_RESET = 5'd12;
    localparam logic [3:0]  MAX_FIELD_SIZE      = 4'd8;
    localparam logic [7:0]  END_HEADER          = 8'h00;
    localparam logic [62:0] MAX63               = {63{1'b1}};

    typedef enum logic [1:0] {
        ST_RUN,
        ST_END,
        ST_MALFORMED,
        ST_OVERFLOW
    } status_t;

    typedef enum logic [1:0] {
        JOB_RUN,
        JOB_END,
        JOB_MALFORMED
    } job_kind_t;

    typedef struct packed {
        logic        restart;
        job_kind_t   kind;
        logic        sparse;
        logic [63:0] length;
        logic [63:0] delta;
    } job_t;

    typedef struct packed {
        status_t     status;
        logic [62:0] run_length_bytes;
        logic [62:0] run_offset_bytes;
        logic        is_sparse;
        logic [7:0]  run_index;
        logic        last;
    } res_t;

endpackage
`default_nettype wire

[hdl/rld_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run list decoder queue
// Small first-in first-out queue of register entries with a fill count.
// ----------------------------------------------------------------------------
module rld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[hdl/rld_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run list decoder front end
// Parses header and field bytes and hands finished runs, list ends and malformed headers on.
// ----------------------------------------------------------------------------
module rld_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   stream_byte,
    input  wire logic         list_start,
    output logic              job_push,
    output rld_pkg::job_t     job
);

    import rld_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [3:0]  len_size_reg, len_size_next;
    logic [3:0]  off_size_reg, off_size_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] delta_acc_reg, delta_acc_next;
    logic        done_reg, done_next, done_eff;
    logic        restart_reg, restart_next;
    logic [63:0] lane;
    logic [63:0] len_new, delta_new;
    logic [3:0]  cnt_inc;
    logic [3:0]  hdr_len, hdr_off;

    assign lane      = 64'(stream_byte) << {cnt_reg[2:0], 3'b000};
    assign len_new   = len_acc_reg | lane;
    assign cnt_inc   = cnt_reg + 4'd1;
    assign hdr_len   = stream_byte[3:0];
    assign hdr_off   = stream_byte[7:4];
    assign phase_eff = list_start ? PH_HEADER : phase_reg;
    assign done_eff  = list_start ? 1'b0 : done_reg;

    always_comb
    begin
        delta_new = delta_acc_reg | lane;
        if (!off_size_reg[3] && stream_byte[7])
        begin
            delta_new = delta_new | ({64{1'b1}} << {off_size_reg[2:0], 3'b000});
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        len_size_next  = len_size_reg;
        off_size_next  = off_size_reg;
        cnt_next       = cnt_reg;
        len_acc_next   = len_acc_reg;
        delta_acc_next = delta_acc_reg;
        done_next      = done_reg;
        restart_next   = restart_reg;
        job_push       = 1'b0;
        job.restart    = restart_reg || list_start;
        job.kind       = JOB_RUN;
        job.sparse     = (off_size_reg == 4'd0);
        job.length     = len_acc_reg;
        job.delta      = delta_new;
        if (accept)
        begin
            if (list_start)
            begin
                phase_next   = PH_HEADER;
                done_next    = 1'b0;
                restart_next = 1'b1;
            end
            if (!done_eff)
            begin
                case (phase_eff)
                    PH_HEADER:
                    begin
                        if (stream_byte == END_HEADER)
                        begin
                            job_push  = 1'b1;
                            job.kind  = JOB_END;
                            done_next = 1'b1;
                        end
                        else if (hdr_len == 4'd0 || hdr_len > MAX_FIELD_SIZE ||
                                 hdr_off > MAX_FIELD_SIZE)
                        begin
                            job_push  = 1'b1;
                            job.kind  = JOB_MALFORMED;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            len_size_next  = hdr_len;
                            off_size_next  = hdr_off;
                            cnt_next       = 4'd0;
                            len_acc_next   = '0;
                            delta_acc_next = '0;
                            phase_next     = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        len_acc_next = len_new;
                        cnt_next     = cnt_inc;
                        if (cnt_inc >= len_size_reg)
                        begin
                            cnt_next = 4'd0;
                            if (off_size_reg == 4'd0)
                            begin
                                job_push   = 1'b1;
                                job.length = len_new;
                                phase_next = PH_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_OFFSET;
                            end
                        end
                    end
                    PH_OFFSET:
                    begin
                        delta_acc_next = delta_acc_reg | lane;
                        cnt_next       = cnt_inc;
                        if (cnt_inc >= off_size_reg)
                        begin
                            cnt_next   = 4'd0;
                            job_push   = 1'b1;
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
            if (job_push)
            begin
                restart_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            len_size_reg  <= '0;
            off_size_reg  <= '0;
            cnt_reg       <= '0;
            len_acc_reg   <= '0;
            delta_acc_reg <= '0;
            done_reg      <= 1'b0;
            restart_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_size_reg  <= len_size_next;
            off_size_reg  <= off_size_next;
            cnt_reg       <= cnt_next;
            len_acc_reg   <= len_acc_next;
            delta_acc_reg <= delta_acc_next;
            done_reg      <= done_next;
            restart_reg   <= restart_next;
        end
    end

endmodule
`default_nettype wire

[hdl/rld_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run list decoder back end
// Applies offset deltas to the running cluster and builds the result words.
// ----------------------------------------------------------------------------
module rld_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [4:0]    cluster_shift,
    input  wire logic          job_valid,
    input  wire rld_pkg::job_t job,
    output logic               job_pop,
    input  wire logic          res_full,
    output logic               res_push,
    output rld_pkg::res_t      res
);

    import rld_pkg::*;

    logic        done_reg, done_next, done_eff;
    logic [62:0] running_reg, running_next, running_eff;
    logic [7:0]  count_reg, count_next, count_eff;
    logic [62:0] limit;
    logic [64:0] sum;
    logic        len_ok, start_ok;
    logic [62:0] len_bytes, start_bytes;

    assign job_pop     = job_valid && !res_full;
    assign done_eff    = job.restart ? 1'b0 : done_reg;
    assign running_eff = job.restart ? '0 : running_reg;
    assign count_eff   = job.restart ? '0 : count_reg;
    assign res_push    = job_pop && !done_eff;

    assign limit       = MAX63 >> cluster_shift;
    assign sum         = {2'b00, running_eff} + {job.delta[63], job.delta};
    assign len_ok      = (job.length <= {1'b0, limit});
    assign start_ok    = job.sparse || (!sum[64] && (sum[63:0] <= {1'b0, limit}));
    assign len_bytes   = job.length[62:0] << cluster_shift;
    assign start_bytes = sum[62:0] << cluster_shift;

    always_comb
    begin
        done_next            = done_reg;
        running_next         = running_reg;
        count_next           = count_reg;
        res.status           = ST_RUN;
        res.run_length_bytes = '0;
        res.run_offset_bytes = '0;
        res.is_sparse        = 1'b0;
        res.run_index        = count_eff;
        res.last             = 1'b0;
        if (job_pop)
        begin
            done_next    = done_eff;
            running_next = running_eff;
            count_next   = count_eff;
            if (!done_eff)
            begin
                case (job.kind)
                    JOB_END:
                    begin
                        res.status = ST_END;
                        res.last   = 1'b1;
                        done_next  = 1'b1;
                    end
                    JOB_MALFORMED:
                    begin
                        res.status = ST_MALFORMED;
                        res.last   = 1'b1;
                        done_next  = 1'b1;
                    end
                    JOB_RUN:
                    begin
                        if (!len_ok || !start_ok)
                        begin
                            res.status = ST_OVERFLOW;
                            res.last   = 1'b1;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            res.run_length_bytes = len_bytes;
                            res.is_sparse        = job.sparse;
                            if (!job.sparse)
                            begin
                                res.run_offset_bytes = start_bytes;
                                running_next         = sum[62:0];
                            end
                            if (count_eff != 8'hFF)
                            begin
                                count_next = count_eff + 8'd1;
                            end
                        end
                    end
                    default:
                    begin
                        res.status = ST_MALFORMED;
                        res.last   = 1'b1;
                        done_next  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            running_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            done_reg    <= done_next;
            running_reg <= running_next;
            count_reg   <= count_next;
        end
    end

    a_drop_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop && done_reg && !job.restart) |-> !res_push)
        else $error("result produced for a list that has already ended");

    a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res.last == (res.status != ST_RUN)))
        else $error("last flag does not match result status");

    a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.status == ST_RUN && !job.restart && count_reg != 8'hFF)
        |=> (count_reg == $past(count_reg) + 8'd1))
        else $error("run index did not advance after a decoded run");

endmodule
`default_nettype wire

[hdl/ntfs_runlist_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NTFS run list decoder
// Decodes a run list byte stream into runs with byte-scaled length and start.
//
// The input side is a queue: a word is taken when push is high and full is
// low. Each word is one run list byte, with list_start marking the first
// byte of a new list. Results are read like a queue: while empty is low the
// oldest result is on the result ports, and pop takes it.
// The configuration channel writes cluster_shift when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// One byte is taken every cycle while full is low. A result reaches the
// ports through the run queue between the parser and the cluster adder
// and then through the result queue behind the adder.
// Reset empties both queues, sets cluster_shift to 12 and puts the parser
// at a header. When the receiver stalls, results collect in the result
// queue, then runs collect in the run queue, and full rises once that is
// full as well; nothing is lost.
// ----------------------------------------------------------------------------
module ntfs_runlist_decoder_unit #(
    parameter int JOB_DEPTH = rld_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH = rld_pkg::RES_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  stream_byte,
    input  wire logic        list_start,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       status,
    output logic [62:0]      run_length_bytes,
    output logic [62:0]      run_offset_bytes,
    output logic             is_sparse,
    output logic [7:0]       run_index,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    import rld_pkg::*;

    logic [4:0] cluster_shift_reg, cluster_shift_next;
    logic       accept;
    logic       job_push, job_pop, job_empty;
    job_t       job_wr, job_rd;
    logic       res_push, res_full;
    res_t       res_wr, res_rd;

    assign cfg_ready          = 1'b1;
    assign cluster_shift_next = (cfg_valid && cfg_ready) ? cfg_data : cluster_shift_reg;
    assign accept             = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_shift_reg <= CLUSTER_SHIFT_RESET;
        end
        else
        begin
            cluster_shift_reg <= cluster_shift_next;
        end
    end

    rld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .list_start  (list_start),
        .job_push    (job_push),
        .job         (job_wr)
    );

    rld_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_wr),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (job_rd),
        .empty   (job_empty)
    );

    rld_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cluster_shift (cluster_shift_reg),
        .job_valid     (!job_empty),
        .job           (job_rd),
        .job_pop       (job_pop),
        .res_full      (res_full),
        .res_push      (res_push),
        .res           (res_wr)
    );

    rld_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign status           = res_rd.status;
    assign run_length_bytes = res_rd.run_length_bytes;
    assign run_offset_bytes = res_rd.run_offset_bytes;
    assign is_sparse        = res_rd.is_sparse;
    assign run_index        = res_rd.run_index;
    assign last             = res_rd.last;

endmodule
`default_nettype wire
